>>> sv/dac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dac_pkg;

  localparam int MEM_WORDS = 100;
  localparam int WORD_BITS = 32;
  localparam int LOC_BITS  = 7;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [LOC_BITS-1:0]  loc_t;
  typedef logic [2:0]           status_t;
  typedef logic [6:0]           opcode_t;

  // Word 0 holds a HALT instruction after reset.
  localparam word_t RESET_WORD0 = word_t'(4300);

  // Result status codes.
  localparam status_t ST_LOADED   = 3'd0;
  localparam status_t ST_EXECUTED = 3'd1;
  localparam status_t ST_HALT     = 3'd2;
  localparam status_t ST_DIVZERO  = 3'd3;
  localparam status_t ST_BADOP    = 3'd4;
  localparam status_t ST_PASTEND  = 3'd5;
  localparam status_t ST_REJECTED = 3'd6;

  // Instruction opcodes.
  localparam opcode_t OP_READ   = 7'd10;
  localparam opcode_t OP_WRITE  = 7'd11;
  localparam opcode_t OP_LOAD   = 7'd20;
  localparam opcode_t OP_STORE  = 7'd21;
  localparam opcode_t OP_ADD    = 7'd30;
  localparam opcode_t OP_SUB    = 7'd31;
  localparam opcode_t OP_DIV    = 7'd32;
  localparam opcode_t OP_MUL    = 7'd33;
  localparam opcode_t OP_BR     = 7'd40;
  localparam opcode_t OP_BRNEG  = 7'd41;
  localparam opcode_t OP_BRZERO = 7'd42;
  localparam opcode_t OP_HALT   = 7'd43;
  // Not an instruction: marks a word that is negative or at or above DECODE_LIMIT.
  localparam opcode_t OP_NONE   = 7'd0;

  // Words at or above this decode to an opcode past HALT.
  localparam int DECODE_LIMIT = 4400;
  localparam int DEC_BITS     = 13;
  // floor(x / 100) == (x * 5243) >> 19 for every x below 43699.
  localparam int RECIP_100    = 5243;
  localparam int RECIP_SHIFT  = 19;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_EXEC,
    S_DIV
  } state_t;

endpackage

`default_nettype wire

>>> sv/dac_div.sv
`timescale 1ns / 1ps
`default_nettype none

module dac_div (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire dac_pkg::word_t dividend,
  input  wire dac_pkg::word_t divisor,
  output logic               done,
  output dac_pkg::word_t     quotient
);
  import dac_pkg::*;

  localparam int CW = $clog2(WORD_BITS);

  logic                 active_r, active_nxt;
  logic                 done_r, done_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [WORD_BITS:0]   rem_r, rem_nxt;
  word_t                quo_r, quo_nxt;
  word_t                dvs_r, dvs_nxt;
  logic                 neg_r, neg_nxt;
  logic [WORD_BITS:0]   rem_sh;
  logic [WORD_BITS:0]   rem_sub;

  // One quotient bit per cycle on magnitudes; the sign is fixed at the end.
  always_comb begin
    active_nxt = active_r;
    done_nxt   = 1'b0;
    cnt_nxt    = cnt_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    dvs_nxt    = dvs_r;
    neg_nxt    = neg_r;
    rem_sh     = {rem_r[WORD_BITS-1:0], quo_r[WORD_BITS-1]};
    rem_sub    = rem_sh - {1'b0, dvs_r};
    if (start) begin
      active_nxt = 1'b1;
      cnt_nxt    = '0;
      rem_nxt    = '0;
      quo_nxt    = dividend[WORD_BITS-1] ? word_t'(-dividend) : dividend;
      dvs_nxt    = divisor[WORD_BITS-1] ? word_t'(-divisor) : divisor;
      neg_nxt    = dividend[WORD_BITS-1] ^ divisor[WORD_BITS-1];
    end else if (active_r) begin
      if (!rem_sub[WORD_BITS]) begin
        rem_nxt = rem_sub;
      end else begin
        rem_nxt = rem_sh;
      end
      quo_nxt = {quo_r[WORD_BITS-2:0], !rem_sub[WORD_BITS]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(WORD_BITS - 1)) begin
        active_nxt = 1'b0;
        done_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      active_r <= active_nxt;
      done_r   <= done_nxt;
      cnt_r    <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? word_t'(-quo_r) : quo_r;

endmodule

`default_nettype wire

>>> sv/decimal_accumulator_cpu_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Transfer condition      Payload
// input     in         start && !busy          in_cmd, in_word
// result    out        out_valid (one cycle)   out_status, out_write_valid,
//                                              out_write_value, out_read_taken,
//                                              out_next_location, out_acc_value
// A load or a rejected step gives its result in the cycle after the transfer,
// and busy stays low, so loads follow one per cycle.
// An executed instruction goes through instruction fetch, operand read and
// execute; both reads go through the registered read port of the main memory.
// DIVIDE then waits in a divide state for the one-bit-per-cycle divider.
// Reset sets the state at once; memory words carry valid bits, so no clear pass.
// The receiver cannot stall; a result is shown for exactly one cycle.
module decimal_accumulator_cpu_unit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              in_cmd,
  input  wire dac_pkg::word_t    in_word,
  output logic                   out_valid,
  output dac_pkg::status_t       out_status,
  output logic                   out_write_valid,
  output dac_pkg::word_t         out_write_value,
  output logic                   out_read_taken,
  output dac_pkg::loc_t          out_next_location,
  output dac_pkg::word_t         out_acc_value
);
  import dac_pkg::*;

  state_t  state_r, state_nxt;
  word_t   acc_r, acc_nxt;
  loc_t    ic_r, ic_nxt;
  loc_t    lp_r, lp_nxt;
  logic    started_r, started_nxt;
  logic    halted_r, halted_nxt;
  word_t   word_r, word_nxt;
  opcode_t op_r, op_nxt;
  loc_t    a_r, a_nxt;

  logic    ov_r, ov_nxt;
  status_t ost_r, ost_nxt;
  logic    owv_r, owv_nxt;
  word_t   owval_r, owval_nxt;
  logic    ort_r, ort_nxt;
  loc_t    onl_r, onl_nxt;

  word_t                  mem [MEM_WORDS];
  logic [MEM_WORDS-1:0]   vld_r;
  word_t                  mem_q_r;
  logic                   mem_vld_q_r;
  logic                   rd_zero_r;
  loc_t                   rd_addr;
  logic                   mem_we;
  loc_t                   mem_wa;
  word_t                  mem_wd;
  word_t                  m_word;

  logic                   acc_fire;
  logic                   ir_ok;
  logic [DEC_BITS-1:0]    dec_x;
  logic [2*DEC_BITS-1:0]  dec_prod;
  opcode_t                dec_q;
  loc_t                   dec_a;

  logic                   div_start;
  logic                   div_done;
  word_t                  div_q;

  assign busy     = (state_r != S_IDLE);
  assign acc_fire = start && !busy;

  // Memory word as read, with unwritten words showing their reset value.
  always_comb begin
    if (mem_vld_q_r) begin
      m_word = mem_q_r;
    end else if (rd_zero_r) begin
      m_word = RESET_WORD0;
    end else begin
      m_word = '0;
    end
  end

  // Split the fetched word into opcode and address by a reciprocal multiply.
  assign ir_ok    = !m_word[WORD_BITS-1] && (m_word < word_t'(DECODE_LIMIT));
  assign dec_x    = m_word[DEC_BITS-1:0];
  assign dec_prod = (2*DEC_BITS)'(dec_x) * (2*DEC_BITS)'(RECIP_100);
  assign dec_q    = dec_prod[RECIP_SHIFT +: LOC_BITS];
  assign dec_a    = LOC_BITS'(dec_x - DEC_BITS'(dec_q) * DEC_BITS'(MEM_WORDS));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc_fire && in_cmd && !halted_r && (ic_r < loc_t'(MEM_WORDS))) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: state_nxt = S_EXEC;
      S_EXEC: begin
        if (op_r == OP_DIV && m_word != '0) begin
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath, memory port and result register controls.
  always_comb begin
    acc_nxt     = acc_r;
    ic_nxt      = ic_r;
    lp_nxt      = lp_r;
    started_nxt = started_r;
    halted_nxt  = halted_r;
    word_nxt    = word_r;
    op_nxt      = op_r;
    a_nxt       = a_r;
    ov_nxt      = 1'b0;
    ost_nxt     = ST_EXECUTED;
    owv_nxt     = 1'b0;
    owval_nxt   = '0;
    ort_nxt     = 1'b0;
    onl_nxt     = ic_r;
    rd_addr     = ic_r;
    mem_we      = 1'b0;
    mem_wa      = a_r;
    mem_wd      = word_r;
    div_start   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (acc_fire) begin
          word_nxt = in_word;
          if (!in_cmd) begin
            // Program load at the load pointer.
            ov_nxt = 1'b1;
            if (started_r || lp_r >= loc_t'(MEM_WORDS)) begin
              ost_nxt = ST_REJECTED;
              onl_nxt = lp_r;
            end else begin
              mem_we  = 1'b1;
              mem_wa  = lp_r;
              mem_wd  = in_word;
              lp_nxt  = lp_r + 1'b1;
              ost_nxt = ST_LOADED;
              onl_nxt = lp_r + 1'b1;
            end
          end else if (halted_r) begin
            ov_nxt  = 1'b1;
            ost_nxt = ST_REJECTED;
          end else if (ic_r >= loc_t'(MEM_WORDS)) begin
            ov_nxt      = 1'b1;
            ost_nxt     = ST_PASTEND;
            started_nxt = 1'b1;
            halted_nxt  = 1'b1;
          end else begin
            started_nxt = 1'b1;
          end
        end
      end
      S_DECODE: begin
        // The instruction word is here; start the operand read.
        ic_nxt  = ic_r + 1'b1;
        op_nxt  = ir_ok ? dec_q : OP_NONE;
        a_nxt   = ir_ok ? dec_a : '0;
        rd_addr = ir_ok ? dec_a : '0;
      end
      S_EXEC: begin
        ov_nxt = 1'b1;
        unique case (op_r)
          OP_READ: begin
            mem_we  = 1'b1;
            mem_wd  = word_r;
            ort_nxt = 1'b1;
          end
          OP_WRITE: begin
            owv_nxt   = 1'b1;
            owval_nxt = m_word;
          end
          OP_LOAD:  acc_nxt = m_word;
          OP_STORE: begin
            mem_we = 1'b1;
            mem_wd = acc_r;
          end
          OP_ADD:   acc_nxt = acc_r + m_word;
          OP_SUB:   acc_nxt = acc_r - m_word;
          OP_DIV: begin
            if (m_word == '0) begin
              ost_nxt    = ST_DIVZERO;
              halted_nxt = 1'b1;
            end else begin
              ov_nxt    = 1'b0;
              div_start = 1'b1;
            end
          end
          OP_MUL:   acc_nxt = word_t'(acc_r * m_word);
          OP_BR:    ic_nxt = a_r;
          OP_BRNEG: begin
            if (acc_r[WORD_BITS-1]) begin
              ic_nxt = a_r;
            end
          end
          OP_BRZERO: begin
            if (acc_r == '0) begin
              ic_nxt = a_r;
            end
          end
          OP_HALT: begin
            ost_nxt    = ST_HALT;
            halted_nxt = 1'b1;
          end
          default: begin
            ost_nxt    = ST_BADOP;
            halted_nxt = 1'b1;
          end
        endcase
        onl_nxt = ic_nxt;
      end
      S_DIV: begin
        if (div_done) begin
          ov_nxt  = 1'b1;
          acc_nxt = div_q;
        end
      end
      default: ;
    endcase
  end

  // Control and architectural registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      acc_r     <= '0;
      ic_r      <= '0;
      lp_r      <= '0;
      started_r <= 1'b0;
      halted_r  <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      acc_r     <= acc_nxt;
      ic_r      <= ic_nxt;
      lp_r      <= lp_nxt;
      started_r <= started_nxt;
      halted_r  <= halted_nxt;
      ov_r      <= ov_nxt;
    end
    word_r  <= word_nxt;
    op_r    <= op_nxt;
    a_r     <= a_nxt;
    ost_r   <= ost_nxt;
    owv_r   <= owv_nxt;
    owval_r <= owval_nxt;
    ort_r   <= ort_nxt;
    onl_r   <= onl_nxt;
  end

  // Main memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q_r     <= mem[rd_addr];
    mem_vld_q_r <= vld_r[rd_addr] && !(mem_we && mem_wa == rd_addr);
    rd_zero_r   <= (rd_addr == '0);
  end

  // Written-word flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (mem_we) begin
      vld_r[mem_wa] <= 1'b1;
    end
  end

  dac_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_r),
    .divisor  (m_word),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_valid         = ov_r;
  assign out_status        = ost_r;
  assign out_write_valid   = owv_r;
  assign out_write_value   = owval_r;
  assign out_read_taken    = ort_r;
  assign out_next_location = onl_r;
  assign out_acc_value     = acc_r;

`ifndef SYNTHESIS
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(acc_fire) || $past(state_r == S_EXEC) || $past(state_r == S_DIV))
    else $error("result strobe without a transfer or an execute step");
  a_halt_implies_start: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> started_r)
    else $error("machine halted without having started");
  a_counters_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ic_r <= loc_t'(MEM_WORDS)) && (lp_r <= loc_t'(MEM_WORDS)))
    else $error("location counter beyond the memory size");
  a_div_start_exec: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (state_r == S_EXEC) && (op_r == OP_DIV))
    else $error("divider started outside a divide instruction");
  a_idle_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) && !div_start |=> (state_r == S_IDLE))
    else $error("execute step did not return to idle");
`endif

endmodule

`default_nettype wire
